>>> design/assert_macros.svh
// Assertion macros for the checker file of the packed state store.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted
`define PMSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Signal holds its value in the cycle after a condition
`define PMSS_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    `PMSS_ASSERT(label, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

>>> design/pmss_pkg.sv
// Package for the packed state store: widths, codes, config/location structs
// and the helper functions for field width, field maximum, per-word count, reciprocal divide and fill word.
// No dependencies.
package pmss_pkg;

    localparam int FUNC_W     = 2;
    localparam int INDEX_W    = 12;
    localparam int VALUE_W    = 8;
    localparam int COUNT_W    = 13;
    localparam int BPS_W      = 4;
    localparam int WORD_W     = 16;
    localparam int WADDR_W    = INDEX_W - 1;    // index / 2 at most
    localparam int OFF_W      = 4;
    localparam int PW_W       = 5;
    localparam int RECIP_W    = 12;
    localparam int SHIFT_W    = 4;
    localparam int PROD_W     = INDEX_W + RECIP_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MAX_STATES = 4096;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Register select (paddr bit 2)
    localparam logic REG_BITS_PER_STATE = 1'b0;
    localparam logic REG_DEFAULT_STATE  = 1'b1;

    localparam logic [BPS_W-1:0]  BPS_MIN   = 4'd1;
    localparam logic [BPS_W-1:0]  BPS_MAX   = 4'd8;
    localparam logic [WORD_W-1:0] WORD_ONES = 16'hffff;

    typedef struct packed {
        logic [BPS_W-1:0]   eff_bits;
        logic [VALUE_W-1:0] field_max;
        logic [VALUE_W-1:0] default_state;
        logic [WORD_W-1:0]  fill_word;
        logic [RECIP_W-1:0] recip_mult;
        logic [SHIFT_W-1:0] recip_shift;
        logic               empty;          // register write empties the store
    } t_cfg;

    typedef struct packed {
        logic [WADDR_W-1:0] word;
        logic [OFF_W-1:0]   off;
    } t_loc;

    // Out-of-range widths saturate to 1..8
    function automatic logic [BPS_W-1:0] eff_bits(input logic [BPS_W-1:0] bps);
        if (bps < BPS_MIN) return BPS_MIN;
        if (bps > BPS_MAX) return BPS_MAX;
        return bps;
    endfunction

    function automatic logic [VALUE_W-1:0] field_max(input logic [BPS_W-1:0] eb);
        return VALUE_W'((9'd1 << eb) - 9'd1);
    endfunction

    function automatic logic [PW_W-1:0] per_word(input logic [BPS_W-1:0] eb);
        case (eb)
            4'd1:    return 5'd16;
            4'd2:    return 5'd8;
            4'd3:    return 5'd5;
            4'd4:    return 5'd4;
            4'd5:    return 5'd3;
            default: return 5'd2;
        endcase
    endfunction

    // index / per_word == (index * mult) >> shift, exact for 12-bit index
    function automatic logic [RECIP_W-1:0] recip_mult(input logic [BPS_W-1:0] eb);
        case (eb)
            4'd3:    return 12'd3277;   // divide by 5
            4'd5:    return 12'd2731;   // divide by 3
            default: return 12'd1;
        endcase
    endfunction

    function automatic logic [SHIFT_W-1:0] recip_shift(input logic [BPS_W-1:0] eb);
        case (eb)
            4'd1:    return 4'd4;
            4'd2:    return 4'd3;
            4'd3:    return 4'd14;
            4'd4:    return 4'd2;
            4'd5:    return 4'd13;
            default: return 4'd1;
        endcase
    endfunction

    // Word given to freshly allocated words; an oversize default spills over
    function automatic logic [WORD_W-1:0] fill_word(input logic [BPS_W-1:0] eb,
                                                    input logic [VALUE_W-1:0] dflt);
        logic [WORD_W-1:0]  w;
        logic [VALUE_W-1:0] mx;
        logic [PW_W-1:0]    n;
        int                 sh;
        w  = '0;
        mx = field_max(eb);
        n  = per_word(eb);
        if (dflt == '0) return '0;
        if (dflt == mx) return WORD_ONES;
        for (int i = 0; i < WORD_W; i++) begin
            if (i < int'(n)) begin
                sh = i * int'(eb);
                w  = w | WORD_W'(32'(dflt) << sh);
            end
        end
        return w;
    endfunction

endpackage

>>> design/packed_multibit_state_store.sv
// Packed multi-bit state store, top level; uses pmss_pkg, pmss_cfg, pmss_addr,
// pmss_ctrl and pmss_mem. An accepted transaction passes S_ADDR, S_FILL for
// each fresh word filled ahead of a write that extends the store, and S_FIN,
// which registers the result; one transaction at a time, bound by the read
// then write of the single word RAM. Reset: synchronous active low, clears
// count, fill count, handshake state; RAM not cleared, no clearing pass.
module packed_multibit_state_store #(
    parameter int STORE_WORDS = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pmss_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pmss_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pmss_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [pmss_pkg::FUNC_W-1:0]       i_func,
    input  logic [pmss_pkg::INDEX_W-1:0]      i_index,
    input  logic [pmss_pkg::VALUE_W-1:0]      i_value,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pmss_pkg::VALUE_W-1:0]      o_read_value,
    output logic [pmss_pkg::COUNT_W-1:0]      o_state_count,
    output logic                              o_rejected
);
    import pmss_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);

    t_cfg              cfg;
    t_loc              loc;
    logic              accept;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    assign accept = i_in_valid && !o_in_stall;

    pmss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pmss_addr u_addr (
        .i_clk    (i_clk),
        .i_accept (accept),
        .i_index  (i_index),
        .i_cfg    (cfg),
        .o_loc    (loc)
    );

    pmss_ctrl #(.STORE_WORDS(STORE_WORDS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_loc         (loc),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_index       (i_index),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_state_count (o_state_count),
        .o_rejected    (o_rejected),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    pmss_mem #(.DEPTH(STORE_WORDS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

>>> design/pmss_cfg.sv
// APB-style configuration registers and the derived field parameters.
// Depends on pmss_pkg.
module pmss_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pmss_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pmss_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pmss_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output pmss_pkg::t_cfg                    o_cfg
);
    import pmss_pkg::*;

    logic [BPS_W-1:0]   r_bits_per_state;
    logic [VALUE_W-1:0] r_default_state;
    logic [WORD_W-1:0]  r_fill_word;
    logic [BPS_W-1:0]   eb;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign eb     = eff_bits(r_bits_per_state);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_per_state <= BPS_MIN;
            r_default_state  <= '0;
        end else if (wr) begin
            case (paddr[APB_ADDR_W-1])
                REG_BITS_PER_STATE: r_bits_per_state <= pwdata[BPS_W-1:0];
                REG_DEFAULT_STATE:  r_default_state  <= pwdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // Fill word kept registered; the user is to change config only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_fill_word <= fill_word(eb, r_default_state);
    end

    // Readback
    always_comb begin
        case (paddr[APB_ADDR_W-1])
            REG_BITS_PER_STATE: prdata = APB_DATA_W'(r_bits_per_state);
            REG_DEFAULT_STATE:  prdata = APB_DATA_W'(r_default_state);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.eff_bits      = eb;
        o_cfg.field_max     = field_max(eb);
        o_cfg.default_state = r_default_state;
        o_cfg.fill_word     = r_fill_word;
        o_cfg.recip_mult    = recip_mult(eb);
        o_cfg.recip_shift   = recip_shift(eb);
        o_cfg.empty         = wr;
    end

endmodule

>>> design/pmss_addr.sv
// Index to word address and bit offset: reciprocal multiply, registered,
// then shift and remainder. Depends on pmss_pkg.
module pmss_addr (
    input  logic                           i_clk,
    input  logic                           i_accept,
    input  logic [pmss_pkg::INDEX_W-1:0]   i_index,
    input  pmss_pkg::t_cfg                 i_cfg,
    output pmss_pkg::t_loc                 o_loc
);
    import pmss_pkg::*;

    logic [PROD_W-1:0]  r_prod;
    logic [INDEX_W-1:0] r_idx;
    logic [WADDR_W-1:0] word;
    logic [INDEX_W-1:0] word_x_n;
    logic [OFF_W-1:0]   rem;

    // Multiply by reciprocal on accept
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prod <= PROD_W'(i_index) * PROD_W'(i_cfg.recip_mult);
            r_idx  <= i_index;
        end
    end

    assign word = WADDR_W'(r_prod >> i_cfg.recip_shift);

    // word * per_word by shifts and adds
    always_comb begin
        case (i_cfg.eff_bits)
            4'd1:    word_x_n = INDEX_W'(word) << 4;
            4'd2:    word_x_n = INDEX_W'(word) << 3;
            4'd3:    word_x_n = (INDEX_W'(word) << 2) + INDEX_W'(word);
            4'd4:    word_x_n = INDEX_W'(word) << 2;
            4'd5:    word_x_n = (INDEX_W'(word) << 1) + INDEX_W'(word);
            default: word_x_n = INDEX_W'(word) << 1;
        endcase
    end

    assign rem       = OFF_W'(r_idx - word_x_n);
    assign o_loc.word = word;
    assign o_loc.off  = OFF_W'(8'(rem) * 8'(i_cfg.eff_bits));

endmodule

>>> design/pmss_mem.sv
// Word store: 16-bit synchronous RAM, one write and one read port,
// registered read data. No dependencies beyond pmss_pkg widths.
module pmss_mem #(
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [pmss_pkg::WORD_W-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [pmss_pkg::WORD_W-1:0]   o_rdata
);
    import pmss_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pmss_ctrl.sv
// Sequencer: decode, fill sweep of fresh words, read-modify-write of the
// addressed word, count and output register. Depends on pmss_pkg.
module pmss_ctrl #(
    parameter  int STORE_WORDS = 2048,
    localparam int AW          = $clog2(STORE_WORDS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pmss_pkg::t_cfg                 i_cfg,
    input  pmss_pkg::t_loc                 i_loc,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pmss_pkg::FUNC_W-1:0]    i_func,
    input  logic [pmss_pkg::INDEX_W-1:0]   i_index,
    input  logic [pmss_pkg::VALUE_W-1:0]   i_value,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pmss_pkg::VALUE_W-1:0]   o_read_value,
    output logic [pmss_pkg::COUNT_W-1:0]   o_state_count,
    output logic                           o_rejected,
    // word store
    output logic                           o_mem_we,
    output logic [AW-1:0]                  o_mem_waddr,
    output logic [pmss_pkg::WORD_W-1:0]    o_mem_wdata,
    output logic                           o_mem_re,
    output logic [AW-1:0]                  o_mem_raddr,
    input  logic [pmss_pkg::WORD_W-1:0]    i_mem_rdata
);
    import pmss_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ADDR, S_FILL, S_FIN} t_state;

    t_state             r_state, n_state;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [INDEX_W-1:0] r_idx, n_idx;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [AW:0]        r_fill_cnt, n_fill_cnt;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic [OFF_W-1:0]   r_off, n_off;
    logic               r_rd_default, n_rd_default;
    logic               r_rej, n_rej;
    logic               r_use_fill, n_use_fill;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_read_value, n_read_value;
    logic [COUNT_W-1:0] r_state_count, n_state_count;
    logic               r_rejected, n_rejected;

    logic               accept, out_free;
    logic               w_big, idx_big;
    logic [VALUE_W-1:0] clamped, extracted;
    logic [WORD_W-1:0]  base, fmask, fval, new_word;
    logic [COUNT_W-1:0] idx_plus1;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_FIN) && out_free));
    assign accept     = i_in_valid && !o_in_stall;

    // Decode checks on the freshly computed location
    assign w_big   = 32'(i_loc.word) >= 32'(STORE_WORDS);
    assign idx_big = 32'(r_idx) >= 32'(MAX_STATES);

    // Field extract and merge
    assign extracted = VALUE_W'(i_mem_rdata >> r_off) & i_cfg.field_max;
    assign clamped   = (r_value > i_cfg.field_max) ? i_cfg.field_max : r_value;
    assign base      = r_use_fill ? i_cfg.fill_word : i_mem_rdata;
    assign fmask     = WORD_W'(i_cfg.field_max) << r_off;
    assign fval      = WORD_W'(clamped) << r_off;
    assign new_word  = (base & ~fmask) | fval;
    assign idx_plus1 = COUNT_W'(r_idx) + COUNT_W'(1);

    // Memory port: read in decode, sweep or merge writes later
    assign o_mem_re    = (r_state == S_ADDR);
    assign o_mem_raddr = AW'(i_loc.word);

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_waddr;
        o_mem_wdata = new_word;
        if (r_state == S_FILL) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = AW'(r_fill_cnt);
            o_mem_wdata = i_cfg.fill_word;
        end else if ((r_state == S_FIN) && out_free && (r_func == FUNC_WRITE) && !r_rej) begin
            o_mem_we = 1'b1;
        end
    end

    // Next-state logic
    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_idx         = r_idx;
        n_value       = r_value;
        n_count       = r_count;
        n_fill_cnt    = r_fill_cnt;
        n_waddr       = r_waddr;
        n_off         = r_off;
        n_rd_default  = r_rd_default;
        n_rej         = r_rej;
        n_use_fill    = r_use_fill;
        n_out_valid   = r_out_valid;
        n_read_value  = r_read_value;
        n_state_count = r_state_count;
        n_rejected    = r_rejected;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: ;
            S_ADDR: begin
                n_waddr      = AW'(i_loc.word);
                n_off        = i_loc.off;
                n_rd_default = (COUNT_W'(r_idx) >= r_count) || w_big;
                n_rej        = (r_func == FUNC_WRITE) && (idx_big || w_big);
                n_use_fill   = 32'(i_loc.word) >= 32'(r_fill_cnt);
                if ((r_func == FUNC_WRITE) && !idx_big && !w_big &&
                    (32'(i_loc.word) > 32'(r_fill_cnt))) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FILL: begin
                // one fresh word per cycle up to the addressed word
                n_fill_cnt = r_fill_cnt + 1'b1;
                if ((r_fill_cnt + 1'b1) == {1'b0, r_waddr}) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_read_value = '0;
                    case (r_func)
                        FUNC_READ: begin
                            n_read_value = r_rd_default ? i_cfg.default_state : extracted;
                        end
                        FUNC_WRITE: begin
                            if (!r_rej) begin
                                n_read_value = clamped;
                                if (idx_plus1 > r_count) n_count = idx_plus1;
                                if (r_use_fill) n_fill_cnt = {1'b0, r_waddr} + 1'b1;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count    = '0;
                            n_fill_cnt = '0;
                        end
                        default: ;
                    endcase
                    n_out_valid   = 1'b1;
                    n_state_count = n_count;
                    n_rejected    = r_rej;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Transaction accepted: latch item, start address calculation
        if (accept) begin
            n_func  = i_func;
            n_idx   = i_index;
            n_value = i_value;
            n_state = S_ADDR;
        end

        // Register write empties the store
        if (i_cfg.empty) begin
            n_count    = '0;
            n_fill_cnt = '0;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_func        <= n_func;
            r_idx         <= n_idx;
            r_value       <= n_value;
            r_count       <= n_count;
            r_fill_cnt    <= n_fill_cnt;
            r_waddr       <= n_waddr;
            r_off         <= n_off;
            r_rd_default  <= n_rd_default;
            r_rej         <= n_rej;
            r_use_fill    <= n_use_fill;
            r_out_valid   <= n_out_valid;
            r_read_value  <= n_read_value;
            r_state_count <= n_state_count;
            r_rejected    <= n_rejected;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_state_count = r_state_count;
    assign o_rejected    = r_rejected;

endmodule

>>> design/pmss_checker.sv
// Port-level checks for the packed state store, bound to the top level.
// Depends on pmss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pmss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [pmss_pkg::APB_ADDR_W-1:0]   paddr,
    input logic [pmss_pkg::APB_DATA_W-1:0]   pwdata,
    input logic [pmss_pkg::APB_DATA_W-1:0]   prdata,
    input logic                              pready,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [pmss_pkg::FUNC_W-1:0]       i_func,
    input logic [pmss_pkg::INDEX_W-1:0]      i_index,
    input logic [pmss_pkg::VALUE_W-1:0]      i_value,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [pmss_pkg::VALUE_W-1:0]      o_read_value,
    input logic [pmss_pkg::COUNT_W-1:0]      o_state_count,
    input logic                              o_rejected
);
    import pmss_pkg::*;

    // One transaction in flight: stall rises straight after an accept
    `PMSS_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input accepted while previous transaction still in flight")

    // A rejected write reports no value
    `PMSS_ASSERT(a_rej_no_value, i_clk, i_rst_n, (o_out_valid && o_rejected) |-> (o_read_value == '0), "rejected write returned a value")

    // Count never exceeds capacity
    `PMSS_ASSERT(a_count_cap, i_clk, i_rst_n, o_out_valid |-> (o_state_count <= COUNT_W'(MAX_STATES)), "state count beyond capacity")

    // Stalled result stays offered, with its state count unchanged
    `PMSS_ASSERT(a_out_valid_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "result withdrawn while stalled")
    `PMSS_ASSERT_HOLD(a_out_data_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_state_count, "stalled state count changed")

endmodule

bind packed_multibit_state_store pmss_checker u_pmss_checker (.*);
